>>> design/ade_pkg.sv
package ade_pkg;

   localparam int DEF_SAMPLE_WIDTH    = 24;
   localparam int DEF_LOG_TABLE_DEPTH = 256;

   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 24;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int DIV_W   = 64;

   localparam int DB_PER_OCT_Q16 = 394566;
   localparam int OCT_PER_DB_Q16 = 10885;
   localparam int KNEE_MIN       = 26;

   localparam logic signed [15:0] RST_THRESHOLD = -16'sd2560;
   localparam logic [12:0]        RST_RATIO     = 13'd1280;
   localparam logic [12:0]        RST_KNEE      = 13'd0;
   localparam logic               RST_FORCE     = 1'b0;
   localparam logic [15:0]        RST_ATTACK    = 16'd65475;
   localparam logic [15:0]        RST_RELEASE   = 16'd65520;
   localparam logic [15:0]        RST_HOLD      = 16'd2400;

   typedef enum logic [2:0] {
      CSR_THRESHOLD,
      CSR_RATIO,
      CSR_KNEE,
      CSR_FORCE_HARD,
      CSR_ATTACK,
      CSR_RELEASE,
      CSR_HOLD
   } csr_index_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_NORM,
      S_IDX_MUL,
      S_IDX_RD,
      S_LV_MUL,
      S_LV_DB,
      S_CV_SEL,
      S_CV_HARD,
      S_CV_SQ,
      S_CV_DIV0,
      S_CV_DIV,
      S_SM_MUL,
      S_SM_UPD,
      S_EXP_MUL,
      S_EXP_SPLIT,
      S_FM_RD,
      S_FM_CMP,
      S_FIN_DIV,
      S_FIN_WAIT,
      S_OUT
   } state_type;

   // log2(1 + i/D) in Q0.16 by repeated squaring of the Q30 mantissa
   function automatic logic [15:0] ltab_entry(input logic [63:0] y0);
      logic [63:0] y;
      logic [15:0] r;
      y = y0;
      r = '0;
      for (int k = 0; k < 16; k++) begin
         y = (y * y) >> 30;
         r = {r[14:0], 1'b0};
         if (y >= (64'd1 << 31)) begin
            y = y >> 1;
            r[0] = 1'b1;
         end
      end
      return r;
   endfunction

   // shift right with round to nearest, ties away from zero
   function automatic logic signed [MUL_P_W-1:0] rnd_shr(
      input logic signed [MUL_P_W-1:0] x, input int unsigned sh);
      logic [MUL_P_W-1:0] m;
      logic [MUL_P_W-1:0] q;
      m = (x < 0) ? MUL_P_W'(-x) : MUL_P_W'(x);
      q = (m + (MUL_P_W'(1) << (sh - 1))) >> sh;
      return (x < 0) ? -$signed(q) : $signed(q);
   endfunction

endpackage

>>> design/ade_if.sv
interface ade_req_if #(
   parameter int SAMPLE_WIDTH = ade_pkg::DEF_SAMPLE_WIDTH
);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

interface ade_rsp_if #(
   parameter int SAMPLE_WIDTH = ade_pkg::DEF_SAMPLE_WIDTH
);
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample_out;
   logic [15:0]             gain_db;

   modport source (output valid, output sample_out, output gain_db, input ready);
   modport sink (input valid, input sample_out, input gain_db, output ready);
endinterface

>>> design/audio_downward_expander_unit.sv
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   sample_in (SAMPLE_WIDTH b signed)
// rsp      out  valid/ready   sample_out (SAMPLE_WIDTH b signed), gain_db (Q7.8)
// csr      in   csr_we        csr_index (3 b), csr_wdata (16 b)
//
// One sample at a time; a zero sample goes straight to the output. The 64-step
// shared restoring divider, one shared multiplier and a binary search over the
// log table do the work.
// Synchronous active-high reset restores the register defaults and 0 dB gain.
// A finished result waits in the output register; the next sample is taken meanwhile.
module audio_downward_expander_unit #(
   parameter int SAMPLE_WIDTH    = ade_pkg::DEF_SAMPLE_WIDTH,
   parameter int LOG_TABLE_DEPTH = ade_pkg::DEF_LOG_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   ade_req_if.sink     req,
   ade_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int W          = SAMPLE_WIDTH;
   localparam int D          = LOG_TABLE_DEPTH;
   localparam int IDX_W      = $clog2(D);
   localparam int LZ_W       = $clog2(W);
   localparam int NORM_STEPS = $clog2(W);
   localparam int K_W        = $clog2(NORM_STEPS);
   localparam int AW         = ade_pkg::MUL_A_W;
   localparam int BW         = ade_pkg::MUL_B_W;
   localparam int PW         = ade_pkg::MUL_P_W;
   localparam int DW         = ade_pkg::DIV_W;

   // log table
   logic [15:0] ltab [D];
   for (genvar gi = 0; gi < D; gi++) begin : g_ltab
      localparam logic [63:0] Y0 = ((64'(D) + 64'(gi)) << 30) / 64'(D);
      assign ltab[gi] = ade_pkg::ltab_entry(Y0);
   end

   ade_pkg::state_type state_ff, state_in;

   logic signed [15:0] thr_ff;
   logic [12:0]        ratio_ff, knee_ff;
   logic               force_ff;
   logic [15:0]        att_ff, rel_ff, hold_ff;

   logic               negx_ff, negx_in;
   logic [W-1:0]       mag_ff, mag_in;
   logic [W-1:0]       nrm_ff, nrm_in;
   logic [LZ_W-1:0]    lz_ff, lz_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic signed [17:0] d_ff, d_in;
   logic signed [16:0] gc_ff, gc_in;
   logic               sgn_ff, sgn_in;
   logic signed [31:0] s_ff, s_in;
   logic [15:0]        cnt_ff, cnt_in;
   logic [5:0]         ssh_ff, ssh_in;
   logic [16:0]        t_ff, t_in;
   logic [IDX_W-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [W-1:0]       ymag_ff, ymag_in;
   logic [15:0]        rom_q_ff;
   logic [IDX_W-1:0]   rom_addr;
   logic signed [PW-1:0] prod_ff;
   logic signed [AW-1:0] mul_a;
   logic signed [BW-1:0] mul_b;

   logic               rsp_valid_ff;
   logic [W-1:0]       rsp_sample_ff;
   logic [15:0]        rsp_gain_ff;
   logic               out_load;

   logic               div_start, div_done;
   logic [DW-1:0]      div_dividend, div_divisor, div_quotient;

   // shared decode
   logic [W-1:0]       raw_mag;
   int unsigned        sh;
   logic               top_zero;
   logic signed [22:0] neg_s;
   logic [PW-1:0]      dbm;
   logic signed [16:0] xdb;
   logic signed [19:0] v, two_w;
   logic               hard_mode, use_hard, v_pos;
   logic signed [PW-1:0] gcv;
   logic [PW-1:0]      m_abs;
   logic [DW-1:0]      q_clip;
   logic signed [33:0] g_ext, s_ext, diff;
   logic               do_att, do_rel;
   logic signed [PW-1:0] e_val;
   logic [IDX_W:0]     span;
   logic [IDX_W-1:0]   mid;
   logic [DW-1:0]      den;

   always_comb begin
      raw_mag   = req.sample_in[W-1] ? (W'(0) - req.sample_in) : req.sample_in;
      sh        = 1 << k_ff;
      top_zero  = (nrm_ff >> (W - sh)) == '0;
      neg_s     = $signed(23'({lz_ff, 16'h0000})) - $signed(23'(rom_q_ff));
      dbm       = PW'((prod_ff + PW'(64'd8388608)) >>> 24);
      if (dbm > PW'(32768)) begin
         dbm = PW'(32768);
      end
      xdb       = -$signed(17'(dbm));
      two_w     = 20'({knee_ff, 1'b0});
      v         = (20'(d_ff) <<< 1) - $signed(20'(knee_ff));
      hard_mode = force_ff || (knee_ff < 13'(ade_pkg::KNEE_MIN));
      use_hard  = hard_mode || ((v + two_w) < 0);
      v_pos     = v > 0;
      gcv       = ade_pkg::rnd_shr(prod_ff, 8);
      m_abs     = (prod_ff < 0) ? PW'(-prod_ff) : PW'(prod_ff);
      q_clip    = (div_quotient > DW'(32768)) ? DW'(32768) : div_quotient;
      g_ext     = 34'($signed({gc_ff, 16'h0000}));
      s_ext     = 34'(s_ff);
      diff      = g_ext - s_ext;
      do_att    = (cnt_ff >= hold_ff) && (g_ext < s_ext);
      do_rel    = !do_att && (g_ext > s_ext);
      e_val     = (prod_ff + PW'(64'd8388608)) >>> 24;
      span      = (IDX_W+1)'(hi_ff) - (IDX_W+1)'(lo_ff) + 1'b1;
      mid       = lo_ff + IDX_W'(span >> 1);
      den       = DW'(D) << ssh_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ade_pkg::S_IDLE: begin
            if (req.valid) begin
               state_in = (raw_mag == '0) ? ade_pkg::S_OUT : ade_pkg::S_NORM;
            end
         end
         ade_pkg::S_NORM: begin
            if (k_ff == '0) begin
               state_in = ade_pkg::S_IDX_MUL;
            end
         end
         ade_pkg::S_IDX_MUL:   state_in = ade_pkg::S_IDX_RD;
         ade_pkg::S_IDX_RD:    state_in = ade_pkg::S_LV_MUL;
         ade_pkg::S_LV_MUL:    state_in = ade_pkg::S_LV_DB;
         ade_pkg::S_LV_DB:     state_in = ade_pkg::S_CV_SEL;
         ade_pkg::S_CV_SEL: begin
            if (use_hard) begin
               state_in = (d_ff < 0) ? ade_pkg::S_CV_HARD : ade_pkg::S_SM_MUL;
            end else begin
               state_in = v_pos ? ade_pkg::S_SM_MUL : ade_pkg::S_CV_SQ;
            end
         end
         ade_pkg::S_CV_HARD:   state_in = ade_pkg::S_SM_MUL;
         ade_pkg::S_CV_SQ:     state_in = ade_pkg::S_CV_DIV0;
         ade_pkg::S_CV_DIV0:   state_in = ade_pkg::S_CV_DIV;
         ade_pkg::S_CV_DIV: begin
            if (div_done) begin
               state_in = ade_pkg::S_SM_MUL;
            end
         end
         ade_pkg::S_SM_MUL: begin
            state_in = (do_att || do_rel) ? ade_pkg::S_SM_UPD : ade_pkg::S_EXP_MUL;
         end
         ade_pkg::S_SM_UPD:    state_in = ade_pkg::S_EXP_MUL;
         ade_pkg::S_EXP_MUL:   state_in = ade_pkg::S_EXP_SPLIT;
         ade_pkg::S_EXP_SPLIT: begin
            state_in = (e_val[15:0] == '0) ? ade_pkg::S_FIN_DIV : ade_pkg::S_FM_RD;
         end
         ade_pkg::S_FM_RD: begin
            state_in = (lo_ff < hi_ff) ? ade_pkg::S_FM_CMP : ade_pkg::S_FIN_DIV;
         end
         ade_pkg::S_FM_CMP:    state_in = ade_pkg::S_FM_RD;
         ade_pkg::S_FIN_DIV:   state_in = ade_pkg::S_FIN_WAIT;
         ade_pkg::S_FIN_WAIT: begin
            if (div_done) begin
               state_in = ade_pkg::S_OUT;
            end
         end
         ade_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = ade_pkg::S_IDLE;
            end
         end
         default: state_in = ade_pkg::S_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      negx_in      = negx_ff;
      mag_in       = mag_ff;
      nrm_in       = nrm_ff;
      lz_in        = lz_ff;
      k_in         = k_ff;
      d_in         = d_ff;
      gc_in        = gc_ff;
      sgn_in       = sgn_ff;
      s_in         = s_ff;
      cnt_in       = cnt_ff;
      ssh_in       = ssh_ff;
      t_in         = t_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      ymag_in      = ymag_ff;
      mul_a        = '0;
      mul_b        = '0;
      rom_addr     = IDX_W'(prod_ff >>> (W - 1));
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      out_load     = 1'b0;
      unique case (state_ff)
         ade_pkg::S_IDLE: begin
            negx_in = req.sample_in[W-1];
            mag_in  = raw_mag;
            nrm_in  = raw_mag;
            lz_in   = '0;
            k_in    = K_W'(NORM_STEPS - 1);
            ymag_in = '0;
         end
         ade_pkg::S_NORM: begin
            if (top_zero) begin
               nrm_in = nrm_ff << sh;
               lz_in  = lz_ff + LZ_W'(sh);
            end
            k_in = k_ff - 1'b1;
         end
         ade_pkg::S_IDX_MUL: begin
            mul_a = AW'(nrm_ff[W-2:0]);
            mul_b = BW'(D);
         end
         ade_pkg::S_IDX_RD: begin
            rom_addr = IDX_W'(prod_ff >>> (W - 1));
         end
         ade_pkg::S_LV_MUL: begin
            mul_a = (neg_s < 0) ? '0 : AW'(neg_s);
            mul_b = BW'(ade_pkg::DB_PER_OCT_Q16);
         end
         ade_pkg::S_LV_DB: begin
            d_in = 18'(xdb) - 18'(thr_ff);
         end
         ade_pkg::S_CV_SEL: begin
            gc_in = '0;
            if (use_hard) begin
               mul_a = AW'(d_ff);
               mul_b = BW'($signed({1'b0, ratio_ff})) - BW'(256);
            end else begin
               mul_a = AW'(v);
               mul_b = BW'(v);
            end
         end
         ade_pkg::S_CV_HARD: begin
            if (gcv > 0) begin
               gc_in = '0;
            end else if (gcv < -PW'(32768)) begin
               gc_in = -17'sd32768;
            end else begin
               gc_in = 17'(gcv);
            end
         end
         ade_pkg::S_CV_SQ: begin
            mul_a = AW'(prod_ff);
            mul_b = BW'(256) - BW'($signed({1'b0, ratio_ff}));
         end
         ade_pkg::S_CV_DIV0: begin
            sgn_in       = prod_ff < 0;
            div_start    = 1'b1;
            div_dividend = DW'(m_abs) + DW'({knee_ff, 10'b0});
            div_divisor  = DW'({knee_ff, 11'b0});
         end
         ade_pkg::S_CV_DIV: begin
            if (div_done) begin
               gc_in = sgn_ff ? -$signed(17'(q_clip)) : '0;
            end
         end
         ade_pkg::S_SM_MUL: begin
            mul_a = diff;
            mul_b = do_att ? BW'(17'h10000 - 17'(att_ff)) : BW'(17'h10000 - 17'(rel_ff));
            if (do_rel) begin
               cnt_in = '0;
            end else if (!do_att && (cnt_ff < hold_ff)) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ade_pkg::S_SM_UPD: begin
            s_in = s_ff + 32'(ade_pkg::rnd_shr(prod_ff, 16));
         end
         ade_pkg::S_EXP_MUL: begin
            mul_a = AW'(0) - AW'(s_ff);
            mul_b = BW'(ade_pkg::OCT_PER_DB_Q16);
         end
         ade_pkg::S_EXP_SPLIT: begin
            t_in  = 17'h10000 - 17'(e_val[15:0]);
            lo_in = '0;
            hi_in = IDX_W'(D - 1);
            if (e_val[15:0] == '0) begin
               ssh_in = 6'(e_val >>> 16);
               mul_a  = AW'(mag_ff);
               mul_b  = BW'(D);
            end else begin
               ssh_in = 6'(e_val >>> 16) + 1'b1;
            end
         end
         ade_pkg::S_FM_RD: begin
            rom_addr = mid;
            mul_a    = AW'(mag_ff);
            mul_b    = BW'(D) + BW'(lo_ff);
         end
         ade_pkg::S_FM_CMP: begin
            if (17'(rom_q_ff) <= t_ff) begin
               lo_in = mid;
            end else begin
               hi_in = mid - 1'b1;
            end
         end
         ade_pkg::S_FIN_DIV: begin
            div_start    = 1'b1;
            div_dividend = DW'(prod_ff) + (den >> 1);
            div_divisor  = den;
         end
         ade_pkg::S_FIN_WAIT: begin
            if (div_done) begin
               ymag_in = (div_quotient > DW'(mag_ff)) ? mag_ff : W'(div_quotient);
            end
         end
         ade_pkg::S_OUT: begin
            out_load = !rsp_valid_ff || rsp.ready;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   ade_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_ff @(posedge clock) begin
      prod_ff  <= mul_a * mul_b;
      rom_q_ff <= ltab[rom_addr];
      negx_ff  <= negx_in;
      mag_ff   <= mag_in;
      nrm_ff   <= nrm_in;
      lz_ff    <= lz_in;
      k_ff     <= k_in;
      d_ff     <= d_in;
      gc_ff    <= gc_in;
      sgn_ff   <= sgn_in;
      ssh_ff   <= ssh_in;
      t_ff     <= t_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      ymag_ff  <= ymag_in;
      if (out_load) begin
         rsp_sample_ff <= negx_ff ? (W'(0) - ymag_ff) : ymag_ff;
         rsp_gain_ff   <= 16'(ade_pkg::rnd_shr(PW'(s_ff), 16));
      end
      if (reset) begin
         state_ff     <= ade_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         s_ff         <= '0;
         cnt_ff       <= '0;
         thr_ff       <= ade_pkg::RST_THRESHOLD;
         ratio_ff     <= ade_pkg::RST_RATIO;
         knee_ff      <= ade_pkg::RST_KNEE;
         force_ff     <= ade_pkg::RST_FORCE;
         att_ff       <= ade_pkg::RST_ATTACK;
         rel_ff       <= ade_pkg::RST_RELEASE;
         hold_ff      <= ade_pkg::RST_HOLD;
      end else begin
         state_ff <= state_in;
         s_ff     <= s_in;
         cnt_ff   <= cnt_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (ade_pkg::csr_index_type'(csr_index))
               ade_pkg::CSR_THRESHOLD:  thr_ff   <= $signed(csr_wdata);
               ade_pkg::CSR_RATIO:      ratio_ff <= csr_wdata[12:0];
               ade_pkg::CSR_KNEE:       knee_ff  <= csr_wdata[12:0];
               ade_pkg::CSR_FORCE_HARD: force_ff <= csr_wdata[0];
               ade_pkg::CSR_ATTACK:     att_ff   <= csr_wdata;
               ade_pkg::CSR_RELEASE:    rel_ff   <= csr_wdata;
               ade_pkg::CSR_HOLD:       hold_ff  <= csr_wdata;
               default: begin
                  force_ff <= force_ff;
               end
            endcase
         end
      end
   end

   assign req.ready      = state_ff == ade_pkg::S_IDLE;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = rsp_sample_ff;
   assign rsp.gain_db    = rsp_gain_ff;

endmodule

>>> design/ade_divider.sv
module ade_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ade_pkg::DIV_W-1:0]  dividend,
   input  logic [ade_pkg::DIV_W-1:0]  divisor,
   output logic                       done,
   output logic [ade_pkg::DIV_W-1:0]  quotient
);
   localparam int DW = ade_pkg::DIV_W;
   localparam int CW = $clog2(DW);

   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] dsr_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   shifted;
   logic          ge;

   always_comb begin
      shifted = {rem_ff[DW-1:0], quo_ff[DW-1]};
      ge      = shifted >= {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? (shifted - {1'b0, dsr_ff}) : shifted;
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) begin
         dsr_ff <= divisor;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
